// ===== sv/tgsd_pkg.sv =====
package tgsd_pkg;

  // Default sizing
  localparam int MAX_OUTLETS_DEF = 8;
  localparam int STOP_BITS_DEF   = 4;

  // Event codes carried in the opcode field
  localparam logic [2:0] OP_READING          = 3'd0;
  localparam logic [2:0] OP_ROUND_END        = 3'd1;
  localparam logic [2:0] OP_MANUAL_STOP      = 3'd2;
  localparam logic [2:0] OP_COLLECTOR_MANUAL = 3'd3;
  localparam logic [2:0] OP_SWITCH_ACK       = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_OUTLET_COUNT      = 3'd0;
  localparam logic [2:0] REG_STOP_MAP          = 3'd1;
  localparam logic [2:0] REG_OFF_WINDOW_MS     = 3'd2;
  localparam logic [2:0] REG_ON_WINDOW_MS      = 3'd3;
  localparam logic [2:0] REG_COLLECTOR_PRESENT = 3'd4;

  // Register reset values
  localparam logic [31:0] OFF_WINDOW_RST = 32'd10000;
  localparam logic [31:0] ON_WINDOW_RST  = 32'd2000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  slot;
    logic [15:0] power_tenths;
    logic        active;
    logic [31:0] now_ms;
    logic [3:0]  stop_value;
    logic        flag;
  } item_t;

  typedef struct packed {
    logic [3:0] requested_stop;
    logic       manual_active;
    logic       switch_cmd_valid;
    logic       switch_cmd_value;
    logic       collector_on;
    logic       collector_forced;
  } result_t;

endpackage

// ===== sv/tgsd_in_stage.sv =====
module tgsd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  tgsd_pkg::item_t item,
  input  logic           take,
  output logic           full,
  output tgsd_pkg::item_t held
);

  logic accept;

  assign item_stall = full && !take;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
  end

endmodule

// ===== sv/tgsd_core.sv =====
module tgsd_core #(
  parameter int MAX_OUTLETS = tgsd_pkg::MAX_OUTLETS_DEF,
  parameter int STOP_BITS   = tgsd_pkg::STOP_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tgsd_pkg::item_t  item,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output tgsd_pkg::result_t result
);

  // Configuration registers
  logic [3:0]  outlet_count;
  logic [31:0] stop_map;
  logic [31:0] off_window_ms;
  logic [31:0] on_window_ms;
  logic        collector_present;

  // Event state
  logic [15:0]          best_power, best_power_next;
  logic [STOP_BITS-1:0] best_stop, best_stop_next;
  logic [STOP_BITS-1:0] pending_stop, pending_stop_next;
  logic                 pending_valid, pending_valid_next;
  logic [31:0]          pending_start, pending_start_next;
  logic [STOP_BITS-1:0] committed_stop, committed_stop_next;
  logic                 manual_hold, manual_hold_next;
  logic                 forced_mode, forced_mode_next;
  logic                 forced_state, forced_state_next;
  logic                 switched_on, switched_on_next;
  logic                 synced, synced_next;
  logic                 cmd_value, cmd_value_next;
  logic                 cmd_outstanding, cmd_outstanding_next;

  logic [31:0]          shift_amt;
  logic [31:0]          map_shifted;
  logic [STOP_BITS-1:0] map_stop;
  logic                 slot_ok;
  logic [31:0]          elapsed;
  logic [31:0]          window;
  logic [STOP_BITS+3:0] sv_wide;
  logic [STOP_BITS+3:0] stop_wide;
  logic                 desired;
  logic                 cmd_valid;
  logic                 cmd_val;

  // Slot to stop lookup; slots past bit 31 of the map read as home
  assign shift_amt   = 32'(item.slot) * 32'(STOP_BITS);
  assign map_shifted = stop_map >> shift_amt[4:0];
  assign map_stop    = (shift_amt >= 32'd32) ? '0 : map_shifted[STOP_BITS-1:0];
  assign slot_ok     = ({1'b0, item.slot} < outlet_count) &&
                       (32'(item.slot) < 32'(MAX_OUTLETS));

  assign elapsed = item.now_ms - pending_start;
  assign window  = (best_stop == '0) ? off_window_ms : on_window_ms;
  assign sv_wide = (STOP_BITS + 4)'(item.stop_value);

  always_comb begin
    best_power_next      = best_power;
    best_stop_next       = best_stop;
    pending_stop_next    = pending_stop;
    pending_valid_next   = pending_valid;
    pending_start_next   = pending_start;
    committed_stop_next  = committed_stop;
    manual_hold_next     = manual_hold;
    forced_mode_next     = forced_mode;
    forced_state_next    = forced_state;
    switched_on_next     = switched_on;
    synced_next          = synced;
    cmd_value_next       = cmd_value;
    cmd_outstanding_next = cmd_outstanding;
    desired              = 1'b0;
    cmd_valid            = 1'b0;
    cmd_val              = 1'b0;
    unique case (item.opcode)
      tgsd_pkg::OP_READING: begin
        if (slot_ok && item.active && (item.power_tenths > best_power)) begin
          best_power_next = item.power_tenths;
          best_stop_next  = map_stop;
        end
      end
      tgsd_pkg::OP_ROUND_END: begin
        if (outlet_count != 4'd0) begin
          if (!pending_valid || (best_stop != pending_stop)) begin
            pending_valid_next = 1'b1;
            pending_stop_next  = best_stop;
            pending_start_next = item.now_ms;
          end else if (elapsed >= window) begin
            if (manual_hold && (best_stop != '0)) begin
              manual_hold_next = 1'b0;
            end
            if (!manual_hold_next && (committed_stop != best_stop)) begin
              committed_stop_next = best_stop;
              forced_mode_next    = 1'b0;
            end
          end
        end
        best_power_next = '0;
        best_stop_next  = '0;
        if (collector_present) begin
          desired = forced_mode_next ? forced_state : (committed_stop_next != '0);
          if (!synced || (desired != switched_on)) begin
            cmd_valid            = 1'b1;
            cmd_val              = desired;
            cmd_value_next       = desired;
            cmd_outstanding_next = 1'b1;
          end
        end
      end
      tgsd_pkg::OP_MANUAL_STOP: begin
        committed_stop_next = sv_wide[STOP_BITS-1:0];
        manual_hold_next    = 1'b1;
      end
      tgsd_pkg::OP_COLLECTOR_MANUAL: begin
        forced_mode_next  = 1'b1;
        forced_state_next = item.flag;
      end
      tgsd_pkg::OP_SWITCH_ACK: begin
        if (cmd_outstanding) begin
          if (item.flag) begin
            switched_on_next = cmd_value;
            synced_next      = 1'b1;
          end
          cmd_outstanding_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign stop_wide = (STOP_BITS + 4)'(committed_stop_next);

  always_comb begin
    result.requested_stop   = stop_wide[3:0];
    result.manual_active    = manual_hold_next;
    result.switch_cmd_valid = cmd_valid;
    result.switch_cmd_value = cmd_val;
    result.collector_on     = switched_on_next;
    result.collector_forced = forced_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outlet_count      <= 4'd0;
      stop_map          <= 32'd0;
      off_window_ms     <= tgsd_pkg::OFF_WINDOW_RST;
      on_window_ms      <= tgsd_pkg::ON_WINDOW_RST;
      collector_present <= 1'b0;
      best_power        <= '0;
      best_stop         <= '0;
      pending_stop      <= '0;
      pending_valid     <= 1'b0;
      pending_start     <= '0;
      committed_stop    <= '0;
      manual_hold       <= 1'b0;
      forced_mode       <= 1'b0;
      forced_state      <= 1'b0;
      switched_on       <= 1'b0;
      synced            <= 1'b0;
      cmd_value         <= 1'b0;
      cmd_outstanding   <= 1'b0;
    end else begin
      if (fire) begin
        best_power      <= best_power_next;
        best_stop       <= best_stop_next;
        pending_stop    <= pending_stop_next;
        pending_valid   <= pending_valid_next;
        pending_start   <= pending_start_next;
        committed_stop  <= committed_stop_next;
        manual_hold     <= manual_hold_next;
        forced_mode     <= forced_mode_next;
        forced_state    <= forced_state_next;
        switched_on     <= switched_on_next;
        synced          <= synced_next;
        cmd_value       <= cmd_value_next;
        cmd_outstanding <= cmd_outstanding_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tgsd_pkg::REG_OUTLET_COUNT:  outlet_count  <= cfg_data[3:0];
          tgsd_pkg::REG_STOP_MAP:      stop_map      <= cfg_data;
          tgsd_pkg::REG_OFF_WINDOW_MS: off_window_ms <= cfg_data;
          tgsd_pkg::REG_ON_WINDOW_MS:  on_window_ms  <= cfg_data;
          tgsd_pkg::REG_COLLECTOR_PRESENT: begin
            collector_present <= cfg_data[0];
            switched_on       <= 1'b0;
            synced            <= 1'b0;
            cmd_outstanding   <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/tgsd_out_stage.sv =====
module tgsd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tgsd_pkg::result_t next_word,
  output logic              free,
  output logic              result_valid,
  input  logic              result_stall,
  output tgsd_pkg::result_t result
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_word;
    end
  end

endmodule

// ===== sv/tool_gate_select_debounce.sv =====
// Gate stop selection with debounce and dust collector control. Each input
// word carries one event: a power reading, a round end with its millisecond
// time stamp, a manual stop override, a forced collector state, or a switch
// acknowledgement. Every accepted word yields exactly one result word with
// the committed stop, override and collector status, plus a collector switch
// command when a round end finds the plug out of step. The block takes one
// word per clock unless item_stall is raised. The accepting edge loads the
// word into the input register. Its single-pass update logic (one 32-bit
// subtract and compare on round end) then writes the state and the result
// register as soon as the result register is free. Both sides are decoupled
// by these two registers; a stalled result only holds off new words once the
// input register is also full. Write configuration only while no word is in
// flight.
module tool_gate_select_debounce #(
  parameter int MAX_OUTLETS = tgsd_pkg::MAX_OUTLETS_DEF,
  parameter int STOP_BITS   = tgsd_pkg::STOP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // event words
  input  logic              item_valid,
  output logic              item_stall,
  input  tgsd_pkg::item_t   item,
  // result words
  output logic              result_valid,
  input  logic              result_stall,
  output tgsd_pkg::result_t result,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic              in_full;
  tgsd_pkg::item_t   in_word;
  logic              out_free;
  logic              advance;
  tgsd_pkg::result_t next_word;

  // Move the held word through the update logic whenever the result
  // register can take it.
  assign advance   = in_full && out_free;
  assign cfg_ready = 1'b1;

  tgsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .take       (advance),
    .full       (in_full),
    .held       (in_word)
  );

  tgsd_core #(
    .MAX_OUTLETS (MAX_OUTLETS),
    .STOP_BITS   (STOP_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (in_word),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (next_word)
  );

  tgsd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .next_word    (next_word),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgsd_pkg::*;

  localparam int STOP_W      = STOP_BITS_DEF;
  localparam int SLOTS       = MAX_OUTLETS_DEF;
  localparam int PHASE_WORDS = 310;
  // Idle time after a drain, once every result is back.
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [31:0] cfg_data     = '0;

  always #2 clk = ~clk;

  tool_gate_select_debounce uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Gate and collector state as the block should hold it
  // ---------------------------------------------------------------------
  logic [3:0]  n_outlets;
  logic [31:0] map_reg;
  logic [31:0] off_win;
  logic [31:0] on_win;
  logic        coll_present;

  logic [15:0] best_power;
  logic [3:0]  best_stop;
  logic [3:0]  pend_stop;
  logic        pend_ok;
  logic [31:0] pend_t0;
  logic [3:0]  commit_stop;
  logic        manual_hold;
  logic        forced_mode;
  logic        forced_state;
  logic        coll_on;
  logic        coll_synced;
  logic        cmd_state;
  logic        cmd_open;

  function automatic void clear_gate_state();
    n_outlets    = '0;
    map_reg      = '0;
    off_win      = OFF_WINDOW_RST;
    on_win       = ON_WINDOW_RST;
    coll_present = 1'b0;
    best_power   = '0;
    best_stop    = '0;
    pend_stop    = '0;
    pend_ok      = 1'b0;
    pend_t0      = '0;
    commit_stop  = '0;
    manual_hold  = 1'b0;
    forced_mode  = 1'b0;
    forced_state = 1'b0;
    coll_on      = 1'b0;
    coll_synced  = 1'b0;
    cmd_state    = 1'b0;
    cmd_open     = 1'b0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_OUTLET_COUNT:  n_outlets = val[3:0];
      REG_STOP_MAP:      map_reg   = val;
      REG_OFF_WINDOW_MS: off_win   = val;
      REG_ON_WINDOW_MS:  on_win    = val;
      REG_COLLECTOR_PRESENT: begin
        // a fresh plug setting forgets what the plug was told
        coll_present = val[0];
        coll_on      = 1'b0;
        coll_synced  = 1'b0;
        cmd_open     = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] stop_of_slot(logic [2:0] s);
    int sh;
    sh = int'(s) * STOP_W;
    if (sh >= 32) return '0;
    return 4'((map_reg >> sh) & ((32'd1 << STOP_W) - 32'd1));
  endfunction

  // Debounce: restart the window whenever the winner changes, commit once
  // it has held for the window that belongs to home or to a tool stop.
  function automatic void settle_stop(logic [31:0] now);
    logic [31:0] window;
    logic [31:0] held;
    if (!pend_ok || best_stop != pend_stop) begin
      pend_ok   = 1'b1;
      pend_stop = best_stop;
      pend_t0   = now;
      return;
    end
    window = (best_stop == '0) ? off_win : on_win;
    held   = now - pend_t0;
    if (held >= window) begin
      if (manual_hold && best_stop != '0) manual_hold = 1'b0;
      if (!manual_hold && commit_stop != best_stop) begin
        commit_stop = best_stop;
        forced_mode = 1'b0;
      end
    end
  endfunction

  function automatic result_t predict_gate_status(item_t w);
    result_t r;
    logic    desired;
    r = '0;
    case (w.opcode)
      OP_READING: begin
        if (w.slot < n_outlets && int'(w.slot) < SLOTS && w.active &&
            w.power_tenths > best_power) begin
          best_power = w.power_tenths;
          best_stop  = stop_of_slot(w.slot);
        end
      end
      OP_ROUND_END: begin
        if (n_outlets != '0) settle_stop(w.now_ms);
        best_power = '0;
        best_stop  = '0;
        if (coll_present) begin
          desired = forced_mode ? forced_state : (commit_stop != '0);
          if (!coll_synced || desired != coll_on) begin
            r.switch_cmd_valid = 1'b1;
            r.switch_cmd_value = desired;
            cmd_state          = desired;
            cmd_open           = 1'b1;
          end
        end
      end
      OP_MANUAL_STOP: begin
        commit_stop = w.stop_value;
        manual_hold = 1'b1;
      end
      OP_COLLECTOR_MANUAL: begin
        forced_mode  = 1'b1;
        forced_state = w.flag;
      end
      OP_SWITCH_ACK: begin
        // an ack with nothing outstanding is dropped
        if (cmd_open) begin
          if (w.flag) begin
            coll_on     = cmd_state;
            coll_synced = 1'b1;
          end
          cmd_open = 1'b0;
        end
      end
      default: ;
    endcase
    r.requested_stop   = commit_stop;
    r.manual_active    = manual_hold;
    r.collector_on     = coll_on;
    r.collector_forced = forced_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Bookkeeping shared by driver, monitor and sequencer
  // ---------------------------------------------------------------------
  item_t   event_backlog[$];
  result_t status_due[$];
  int      words_queued   = 0;
  int      status_checked = 0;
  int      faults         = 0;
  int      cycle_count    = 0;

  // ---------------------------------------------------------------------
  // Driver: send words in bursts of random length with random gaps, and
  // hold the word steady while the block stalls it.
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_events
    logic next_valid;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      // predict at the accepting edge, before the next word is loaded
      if (item_valid && !item_stall) status_due.push_back(predict_gate_status(item));
      if (!item_valid || !item_stall) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_backlog.size() != 0) begin
          item       <= event_backlog.pop_front();
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // a quarter of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
          end
        end
        item_valid <= next_valid;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stall results on a pattern that rotates through four modes,
  // and check each accepted result word against the oldest expectation.
  // ---------------------------------------------------------------------
  int stall_tick = 0;

  always @(posedge clk) begin : check_status
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        status_checked++;
        if (status_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("unexpected result word %h", result);
        end else begin
          want = status_due.pop_front();
          if (result.requested_stop   !== want.requested_stop   ||
              result.manual_active    !== want.manual_active    ||
              result.switch_cmd_valid !== want.switch_cmd_valid ||
              result.switch_cmd_value !== want.switch_cmd_value ||
              result.collector_on     !== want.collector_on     ||
              result.collector_forced !== want.collector_forced) begin
            faults++;
            if (faults <= 10)
              $display({"result %0d mismatch: stop %0d/%0d manual %b/%b cmd %b%b/%b%b ",
                        "on %b/%b forced %b/%b (expected/actual)"},
                       status_checked,
                       want.requested_stop, result.requested_stop,
                       want.manual_active, result.manual_active,
                       want.switch_cmd_valid, want.switch_cmd_value,
                       result.switch_cmd_valid, result.switch_cmd_value,
                       want.collector_on, result.collector_on,
                       want.collector_forced, result.collector_forced);
          end
        end
      end
      stall_tick++;
      case ((stall_tick / 97) % 4)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 1) == 0);
        2:       result_stall <= ((stall_tick % 8) < 3);
        default: result_stall <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  logic [31:0] clock_ms;      // time stamp carried by the next round end
  int          step_cap;      // largest time step between round ends
  logic [2:0]  favored_slot;  // outlet that keeps winning for a while
  logic        quiet;         // outlets rarely active: rounds settle toward home

  task automatic queue_event(item_t w);
    event_backlog.push_back(w);
    words_queued++;
  endtask

  function automatic item_t event_word(logic [2:0] op, logic [2:0] s, logic [15:0] pw,
                                       logic act, logic [31:0] now, logic [3:0] sv,
                                       logic fl);
    item_t w;
    w.opcode       = op;
    w.slot         = s;
    w.power_tenths = pw;
    w.active       = act;
    w.now_ms       = now;
    w.stop_value   = sv;
    w.flag         = fl;
    return w;
  endfunction

  function automatic item_t noise_word();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[59:0];
  endfunction

  // One poll round: readings, maybe an override, the round end and
  // usually the acknowledgement of whatever switch it asked for.
  task automatic queue_round();
    item_t w;
    int    n;
    n = $urandom_range(0, 5);
    repeat (n) begin
      w        = noise_word();
      w.opcode = OP_READING;
      w.slot   = ($urandom_range(0, 3) != 0) ? favored_slot : 3'($urandom_range(0, 7));
      if (w.slot == favored_slot) w.power_tenths = 16'($urandom_range(40000, 65535));
      else                        w.power_tenths = 16'($urandom_range(0, 45000));
      if ($urandom_range(0, 15) == 0) w.power_tenths = '0;
      w.active = quiet ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 7) != 0);
      queue_event(w);
    end
    if ($urandom_range(0, 11) == 0) begin
      w        = noise_word();
      w.opcode = OP_MANUAL_STOP;
      queue_event(w);
    end
    if ($urandom_range(0, 9) == 0) begin
      w        = noise_word();
      w.opcode = OP_COLLECTOR_MANUAL;
      queue_event(w);
    end
    // advance time; now and then step back by one or jump anywhere
    case ($urandom_range(0, 59))
      0:       clock_ms = clock_ms - 32'd1;
      1:       clock_ms = $urandom;
      default: clock_ms = clock_ms + 32'($urandom_range(0, step_cap));
    endcase
    w        = noise_word();
    w.opcode = OP_ROUND_END;
    w.now_ms = clock_ms;
    queue_event(w);
    if ($urandom_range(0, 3) != 0) begin
      w        = noise_word();
      w.opcode = OP_SWITCH_ACK;
      w.flag   = ($urandom_range(0, 4) != 0);
      queue_event(w);
    end
    if ($urandom_range(0, 7) == 0) favored_slot = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) quiet = ~quiet;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Pause the sequence until every queued word has its result back.
  task automatic drain();
    while (status_checked < words_queued) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(logic [3:0] cnt, logic [31:0] map, logic [31:0] off_ms,
                           logic [31:0] on_ms, logic present, int cap);
    int goal;
    drain();
    write_reg(REG_OUTLET_COUNT, 32'(cnt));
    write_reg(REG_STOP_MAP, map);
    write_reg(REG_OFF_WINDOW_MS, off_ms);
    write_reg(REG_ON_WINDOW_MS, on_ms);
    write_reg(REG_COLLECTOR_PRESENT, 32'(present));
    step_cap = cap;
    goal     = words_queued + PHASE_WORDS;
    // mostly well-formed rounds, one pick in ten a pure noise word instead
    while (words_queued < goal) begin
      if ($urandom_range(0, 9) == 0) queue_event(noise_word());
      else queue_round();
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    clear_gate_state();
    clock_ms     = '0;
    step_cap     = 10;
    favored_slot = '0;
    quiet        = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no outlets, no collector.
    queue_event(event_word(OP_READING, 3'd0, 16'hFFFF, 1'b1, '0, '0, 1'b0));
    queue_event(event_word(OP_ROUND_END, 3'd0, '0, 1'b0, 32'd0, '0, 1'b0));
    queue_event(event_word(OP_MANUAL_STOP, 3'd0, '0, 1'b0, '0, 4'd15, 1'b0));
    queue_event(event_word(OP_COLLECTOR_MANUAL, 3'd0, '0, 1'b0, '0, '0, 1'b1));
    queue_event(event_word(OP_SWITCH_ACK, 3'd0, '0, 1'b0, '0, '0, 1'b1));
    queue_event(event_word(3'd5, 3'd7, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'd15, 1'b1));
    queue_event(event_word(3'd6, 3'd2, 16'h1234, 1'b0, 32'h0000_0042, 4'd3, 1'b0));
    queue_event(event_word(3'd7, 3'd5, 16'h8000, 1'b1, 32'h8000_0000, 4'd9, 1'b1));
    drain();

    // Three outlets mapped to stops 3, 5 and 10, short windows, plug fitted.
    write_reg(REG_OUTLET_COUNT, 32'd3);
    write_reg(REG_STOP_MAP, 32'h0000_0A53);
    write_reg(REG_OFF_WINDOW_MS, 32'd10);
    write_reg(REG_ON_WINDOW_MS, 32'd5);
    write_reg(REG_COLLECTOR_PRESENT, 32'd1);
    // zero power, inactive outlet, a winner, an equal reading, a slot past the count
    queue_event(event_word(OP_READING, 3'd0, 16'd0, 1'b1, '0, '0, 1'b0));
    queue_event(event_word(OP_READING, 3'd1, 16'd100, 1'b0, '0, '0, 1'b0));
    queue_event(event_word(OP_READING, 3'd1, 16'd1000, 1'b1, '0, '0, 1'b0));
    queue_event(event_word(OP_READING, 3'd2, 16'd1000, 1'b1, '0, '0, 1'b0));
    queue_event(event_word(OP_READING, 3'd5, 16'hFFFF, 1'b1, '0, '0, 1'b0));
    // first round end restarts the window; forced collector asks for on
    queue_event(event_word(OP_ROUND_END, 3'd0, '0, 1'b0, 32'hFFFF_FFFC, '0, 1'b0));
    queue_event(event_word(OP_SWITCH_ACK, 3'd0, '0, 1'b0, '0, '0, 1'b0));
    // window met across the wrap: tool stop drops the override; retry switch
    queue_event(event_word(OP_READING, 3'd1, 16'd1000, 1'b1, '0, '0, 1'b0));
    queue_event(event_word(OP_ROUND_END, 3'd0, '0, 1'b0, 32'h0000_0002, '0, 1'b0));
    queue_event(event_word(OP_SWITCH_ACK, 3'd0, '0, 1'b0, '0, '0, 1'b1));
    queue_event(event_word(OP_SWITCH_ACK, 3'd0, '0, 1'b0, '0, '0, 1'b1));
    // settle back home, then round end again with the command still open
    queue_event(event_word(OP_ROUND_END, 3'd0, '0, 1'b0, 32'd3, '0, 1'b0));
    queue_event(event_word(OP_ROUND_END, 3'd0, '0, 1'b0, 32'd20, '0, 1'b0));
    queue_event(event_word(OP_ROUND_END, 3'd0, '0, 1'b0, 32'd21, '0, 1'b0));
    queue_event(event_word(OP_SWITCH_ACK, 3'd0, '0, 1'b0, '0, '0, 1'b1));
    queue_event(event_word(OP_MANUAL_STOP, 3'd0, '0, 1'b0, '0, 4'd0, 1'b0));

    // Random phases, each behind a full drain so the sender pauses.
    clock_ms = 32'd100;
    run_phase(4'd8, $urandom, 32'd0, 32'd0, 1'b1, 3);
    clock_ms = 32'hFFFF_FF00;
    run_phase(4'($urandom_range(1, 8)), $urandom, 32'd40, 32'd15, 1'b1, 12);
    run_phase(4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 4);
    run_phase(4'd0, 32'h1234_5678, 32'd5, 32'd5, 1'b1, 10);
    run_phase(4'd1, 32'h0000_000F, 32'hFFFF_FFFF, 32'd0, 1'b1, 10);
    run_phase(4'($urandom_range(2, 8)), $urandom, 32'($urandom_range(0, 60)),
              32'($urandom_range(0, 30)), 1'b1, 20);

    drain();
    if (faults == 0 && status_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
